// File: design/clte_pkg.sv
// Shared types and constants for the character LCD text and cursor engine.
// Used by clte_ctrl, clte_dpath and char_lcd_text_cursor_engine_top.
package clte_pkg;

    // Display geometry
    localparam int ROWS = 2;
    localparam int COLS = 16;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_LAST  = 8'd126;

    // Command codes carried with each input item
    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_EOL   = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_LEFT  = 3'd4,
        CMD_UP    = 3'd5,
        CMD_DOWN  = 3'd6
    } lcd_cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;    // latch a new item, update cursor, arm the scan
        logic issue;    // read the next cell of the scan range
        logic consume;  // retire the cell read in the previous issue
        logic finish;   // emit the closing result of the item
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_left;    // cells of the range still to be read
        logic s1_vld;       // a read cell waits to be compared
        logic can_advance;  // the compare stage may retire its cell
        logic out_free;     // output register can take a result
    } dp_status_t;

endpackage

// File: design/clte_ctrl.sv
// Sequencer for the LCD text engine: accepts items and steps the cell scan.
// Depends on clte_pkg; drives clte_dpath through ctrl_cmd_t.
module clte_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output clte_pkg::ctrl_cmd_t    cmd,
    input  clte_pkg::dp_status_t   status
);
    import clte_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue   = status.scan_left && status.can_advance;
                cmd.consume = status.s1_vld && status.can_advance;
                if (!status.scan_left && !status.s1_vld) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/clte_dpath.sv
// Datapath of the LCD text engine: cursor, sticky error, character memory,
// scan/compare stage, pending-cell holder and output register. Uses clte_pkg.
module clte_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  clte_pkg::ctrl_cmd_t    cmd,
    output clte_pkg::dp_status_t   status,
    input  logic [2:0]             in_command,
    input  logic [7:0]             in_char_code,
    input  logic [7:0]             in_target_row,
    input  logic [7:0]             in_target_column,
    input  logic                   in_set_position,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import clte_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = $clog2(COLS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS - 1);

    // Character memory; a cell never written reads as a space
    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] cell_vld_reg, cell_vld_next;

    // Cursor and flags
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic             err_reg, err_next;
    logic             ok_reg, ok_next;

    // Scan range
    logic [7:0]       new_char_reg, new_char_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic             scan_left_reg, scan_left_next;

    // Compare stage fed by the registered memory read
    logic             s1_vld_reg, s1_vld_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_cv_reg;

    // Changed cell held back until it is known whether it is the last
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    // Output register
    logic             m_vld_reg, m_vld_next;
    logic             m_write_reg, m_write_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [7:0]       m_char_reg, m_char_next;
    logic [ROW_W-1:0] m_row_reg, m_row_next;
    logic [COL_W-1:0] m_col_reg, m_col_next;
    logic             m_ok_reg, m_ok_next;
    logic             m_err_reg, m_err_next;
    logic             m_last_reg, m_last_next;

    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] row_base;
    logic [ROW_W-1:0] rt_row;
    logic [COL_W-1:0] rt_col;
    logic             rt_ok;
    logic             printable;
    logic [7:0]       cell_val;
    logic             s1_chg;
    logic             out_free;
    logic             can_advance;
    logic             wr_en;

    assign row_base  = IDX_W'(cur_row_reg) * IDX_W'(COLS);
    assign cur_idx   = row_base + IDX_W'(cur_col_reg);
    assign printable = (in_char_code >= CHAR_FIRST) && (in_char_code <= CHAR_LAST);

    // Compare the read cell with the character being stored
    assign cell_val    = rd_cv_reg ? rd_data_reg : CHAR_SPACE;
    assign s1_chg      = s1_vld_reg && (cell_val != new_char_reg);
    assign out_free    = !m_vld_reg || m_tready;
    assign can_advance = !(s1_chg && pend_vld_reg && !out_free);
    assign wr_en       = cmd.consume && s1_chg;

    assign status.scan_left   = scan_left_reg;
    assign status.s1_vld      = s1_vld_reg;
    assign status.can_advance = can_advance;
    assign status.out_free    = out_free;

    // One step right along the linear cell order
    always_comb begin
        rt_row = cur_row_reg;
        rt_col = cur_col_reg;
        rt_ok  = 1'b1;
        if (cur_col_reg == COL_LAST) begin
            if (cur_row_reg == ROW_LAST) begin
                rt_ok = 1'b0;
            end else begin
                rt_row = cur_row_reg + 1'b1;
                rt_col = '0;
            end
        end else begin
            rt_col = cur_col_reg + 1'b1;
        end
    end

    // Next-state logic
    always_comb begin
        cell_vld_next  = cell_vld_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        err_next       = err_reg;
        ok_next        = ok_reg;
        new_char_next  = new_char_reg;
        addr_next      = addr_reg;
        hi_next        = hi_reg;
        scan_left_next = scan_left_reg;
        s1_vld_next    = s1_vld_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        m_vld_next     = m_vld_reg && !m_tready;
        m_write_next   = m_write_reg;
        m_idx_next     = m_idx_reg;
        m_char_next    = m_char_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_ok_next      = m_ok_reg;
        m_err_next     = m_err_reg;
        m_last_next    = m_last_reg;

        // New item: cursor update and scan range
        if (cmd.start) begin
            ok_next        = 1'b1;
            scan_left_next = 1'b0;
            addr_next      = cur_idx;
            hi_next        = cur_idx;
            new_char_next  = CHAR_SPACE;
            if (in_set_position) begin
                if ((in_target_row < 8'(ROWS)) && (in_target_column < 8'(COLS))) begin
                    cur_row_next = ROW_W'(in_target_row);
                    cur_col_next = COL_W'(in_target_column);
                end else begin
                    ok_next  = 1'b0;
                    err_next = 1'b1;
                end
            end else begin
                case (in_command)
                    CMD_WRITE: begin
                        if (printable) begin
                            scan_left_next = 1'b1;
                            new_char_next  = in_char_code;
                            cur_row_next   = rt_row;
                            cur_col_next   = rt_col;
                            ok_next        = rt_ok;
                            err_next       = err_reg || !rt_ok;
                        end
                    end
                    CMD_CLEAR: begin
                        scan_left_next = 1'b1;
                        addr_next      = '0;
                        hi_next        = IDX_LAST;
                        cur_row_next   = '0;
                        cur_col_next   = '0;
                    end
                    CMD_EOL: begin
                        scan_left_next = 1'b1;
                        hi_next        = row_base + IDX_W'(COLS - 1);
                    end
                    CMD_RIGHT: begin
                        cur_row_next = rt_row;
                        cur_col_next = rt_col;
                        ok_next      = rt_ok;
                        err_next     = err_reg || !rt_ok;
                    end
                    CMD_LEFT: begin
                        if (cur_col_reg == '0) begin
                            if (cur_row_reg == '0) begin
                                ok_next  = 1'b0;
                                err_next = 1'b1;
                            end else begin
                                cur_row_next = cur_row_reg - 1'b1;
                                cur_col_next = COL_LAST;
                            end
                        end else begin
                            cur_col_next = cur_col_reg - 1'b1;
                        end
                    end
                    CMD_UP: begin
                        if (cur_row_reg == '0) begin
                            cur_col_next = '0;
                            ok_next      = 1'b0;
                            err_next     = 1'b1;
                        end else begin
                            cur_row_next = cur_row_reg - 1'b1;
                        end
                    end
                    CMD_DOWN: begin
                        if (cur_row_reg == ROW_LAST) begin
                            cur_col_next = COL_LAST;
                            ok_next      = 1'b0;
                            err_next     = 1'b1;
                        end else begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // Read side of the scan
        if (cmd.consume) begin
            s1_vld_next = 1'b0;
        end
        if (cmd.issue) begin
            s1_vld_next = 1'b1;
            if (addr_reg == hi_reg) begin
                scan_left_next = 1'b0;
            end else begin
                addr_next = addr_reg + 1'b1;
            end
        end

        // Retire a changed cell; push the one held before it out
        if (wr_en) begin
            cell_vld_next[s1_idx_reg] = 1'b1;
            pend_vld_next             = 1'b1;
            pend_idx_next             = s1_idx_reg;
            if (pend_vld_reg) begin
                m_vld_next   = 1'b1;
                m_write_next = 1'b1;
                m_idx_next   = pend_idx_reg;
                m_char_next  = new_char_reg;
                m_last_next  = 1'b0;
                m_row_next   = cur_row_reg;
                m_col_next   = cur_col_reg;
                m_ok_next    = ok_reg;
                m_err_next   = err_reg;
            end
        end

        // Closing result: last changed cell, or a no-change marker
        if (cmd.finish && out_free) begin
            m_vld_next    = 1'b1;
            m_write_next  = pend_vld_reg;
            m_idx_next    = pend_vld_reg ? pend_idx_reg : '0;
            m_char_next   = pend_vld_reg ? new_char_reg : 8'd0;
            m_last_next   = 1'b1;
            m_row_next    = cur_row_reg;
            m_col_next    = cur_col_reg;
            m_ok_next     = ok_reg;
            m_err_next    = err_reg;
            pend_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg  <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            err_reg       <= 1'b0;
            scan_left_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            pend_vld_reg  <= 1'b0;
            m_vld_reg     <= 1'b0;
        end else begin
            cell_vld_reg  <= cell_vld_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            err_reg       <= err_next;
            scan_left_reg <= scan_left_next;
            s1_vld_reg    <= s1_vld_next;
            pend_vld_reg  <= pend_vld_next;
            m_vld_reg     <= m_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ok_reg       <= ok_next;
        new_char_reg <= new_char_next;
        addr_reg     <= addr_next;
        hi_reg       <= hi_next;
        pend_idx_reg <= pend_idx_next;
        m_write_reg  <= m_write_next;
        m_idx_reg    <= m_idx_next;
        m_char_reg   <= m_char_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_ok_reg     <= m_ok_next;
        m_err_reg    <= m_err_next;
        m_last_reg   <= m_last_next;
    end

    // Memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_idx_reg] <= new_char_reg;
        end
    end

    // Memory read port, registered
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg];
            rd_cv_reg   <= cell_vld_reg[addr_reg];
            s1_idx_reg  <= addr_reg;
        end
    end

    // Result item
    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_write_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_err_reg, m_ok_reg, 4'(m_col_reg), 1'(m_row_reg),
                       m_char_reg, 5'(m_idx_reg)};

endmodule

// File: design/char_lcd_text_cursor_engine_top.sv
// Character LCD text store with cursor: ROWS x COLS cells, one command per item.
// A character write scans its one cell and a full clear all ROWS*COLS cells, one cell
// read per cycle through the single memory read port while the output does not stall
// the scan. Next item accepted in the cycle after the last result is loaded.
// Reset: synchronous, active low; cells read as spaces, cursor at 0,0.
module char_lcd_text_cursor_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [15:8] target_row, [23:16] target_column
    input  logic [23:0] s_tdata,
    // [2:0] command, [3] set_position
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] cell_index, [12:5] cell_char, [13] cursor_row, [17:14] cursor_column,
    // [18] success, [19] error_code, [23:20] zero
    output logic [23:0] m_tdata,
    // [0] cell_write
    output logic        m_tuser,
    output logic        m_tlast
);
    import clte_pkg::*;

    ctrl_cmd_t  ctl_cmd;
    dp_status_t dp_stat;

    clte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (ctl_cmd),
        .status   (dp_stat)
    );

    clte_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (ctl_cmd),
        .status           (dp_stat),
        .in_command       (s_tuser[2:0]),
        .in_char_code     (s_tdata[7:0]),
        .in_target_row    (s_tdata[15:8]),
        .in_target_column (s_tdata[23:16]),
        .in_set_position  (s_tuser[3]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // Ready only when no scan work of the previous item remains
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!dp_stat.scan_left && !dp_stat.s1_vld))
        else $error("input ready while scan still active");

    // A granted finish always presents the closing result next cycle
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_cmd.finish && dp_stat.out_free) |=> (m_tvalid && m_tlast))
        else $error("finish did not produce a last result");

    // Block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held high after accept");
`endif

endmodule

// File: dv/clte_checker.sv
// Scoreboard for the character LCD text and cursor engine: watches both stream
// channels, keeps its own copy of the cell store and cursor, and compares results.
// Depends on clte_pkg for the display size, command codes and character constants.
module clte_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [7:0] char_code, [15:8] target_row, [23:16] target_column
    input  logic [23:0] s_tdata,
    // [2:0] command, [3] set_position
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] cell_index, [12:5] cell_char, [13] cursor_row, [17:14] cursor_column,
    // [18] success, [19] error_code, [23:20] zero
    input  logic [23:0] m_tdata,
    // [0] cell_write
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          items_seen,
    output int          results_seen,
    output int          updates_seen
);
    import clte_pkg::*;

    localparam int CELLS = ROWS * COLS;

    typedef struct {
        logic       cell_write;
        logic [4:0] cell_index;
        logic [7:0] cell_char;
        logic       cursor_row;
        logic [3:0] cursor_column;
        logic       success;
        logic       error_code;
        logic       last;
    } cell_update_t;

    cell_update_t pending_updates[$];
    cell_update_t oldest;
    logic [7:0]   screen[CELLS];
    int           cursor_pos;     // linear index row*COLS+col
    logic         pos_error;

    // Linear cursor move; clamps at either end and flags the sticky error
    function automatic bit shift_cursor(input int offset);
        int p;
        p = cursor_pos + offset;
        if (p < 0) begin
            cursor_pos = 0;
            pos_error  = 1'b1;
            return 1'b0;
        end
        if (p > CELLS - 1) begin
            cursor_pos = CELLS - 1;
            pos_error  = 1'b1;
            return 1'b0;
        end
        cursor_pos = p;
        return 1'b1;
    endfunction

    // Apply one command to the shadow screen and queue the updates it causes
    function automatic void apply_command(input logic [2:0] cmd, input logic [7:0] ch,
                                          input logic [7:0] trow, input logic [7:0] tcol,
                                          input logic setpos);
        bit           changed[CELLS];
        bit           ok;
        int           n;
        int           row_end;
        cell_update_t r;
        ok = 1'b1;
        n  = 0;
        for (int i = 0; i < CELLS; i++) changed[i] = 1'b0;
        if (setpos) begin
            if (trow >= ROWS || tcol >= COLS) begin
                pos_error = 1'b1;
                ok        = 1'b0;
            end else begin
                cursor_pos = trow * COLS + tcol;
            end
        end else begin
            case (cmd)
                CMD_WRITE: begin
                    if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
                        if (screen[cursor_pos] != ch) begin
                            screen[cursor_pos]  = ch;
                            changed[cursor_pos] = 1'b1;
                        end
                        ok = shift_cursor(1);
                    end
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < CELLS; i++) begin
                        if (screen[i] != CHAR_SPACE) begin
                            screen[i]  = CHAR_SPACE;
                            changed[i] = 1'b1;
                        end
                    end
                    cursor_pos = 0;
                end
                CMD_EOL: begin
                    row_end = (cursor_pos / COLS + 1) * COLS;
                    for (int i = cursor_pos; i < row_end; i++) begin
                        if (screen[i] != CHAR_SPACE) begin
                            screen[i]  = CHAR_SPACE;
                            changed[i] = 1'b1;
                        end
                    end
                end
                CMD_RIGHT: ok = shift_cursor(1);
                CMD_LEFT:  ok = shift_cursor(-1);
                CMD_UP:    ok = shift_cursor(-COLS);
                CMD_DOWN:  ok = shift_cursor(COLS);
                default: ;
            endcase
        end

        // Cursor and status fields are shared by all updates of one command
        r.cursor_row    = 1'(cursor_pos / COLS);
        r.cursor_column = 4'(cursor_pos % COLS);
        r.success       = ok;
        r.error_code    = pos_error;
        r.last          = 1'b0;
        for (int i = 0; i < CELLS; i++) begin
            if (changed[i]) begin
                r.cell_write = 1'b1;
                r.cell_index = 5'(i);
                r.cell_char  = screen[i];
                pending_updates.push_back(r);
                n++;
            end
        end
        if (n == 0) begin
            r.cell_write = 1'b0;
            r.cell_index = '0;
            r.cell_char  = '0;
            pending_updates.push_back(r);
        end
        pending_updates[pending_updates.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v,
                     got_v);
        end
    endtask

    // Sample both channels on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CELLS; k++) screen[k] = CHAR_SPACE;
            cursor_pos   = 0;
            pos_error    = 1'b0;
            mismatches   = 0;
            items_seen   = 0;
            results_seen = 0;
            updates_seen = 0;
            pending_updates.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser[2:0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                              s_tuser[3]);
                items_seen++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser) updates_seen++;
                if (pending_updates.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item, expected none, actual data %h user %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    oldest = pending_updates.pop_front();
                    check_field("cell_write", int'(oldest.cell_write), int'(m_tuser));
                    check_field("cell_index", int'(oldest.cell_index), int'(m_tdata[4:0]));
                    check_field("cell_char", int'(oldest.cell_char), int'(m_tdata[12:5]));
                    check_field("cursor_row", int'(oldest.cursor_row), int'(m_tdata[13]));
                    check_field("cursor_column", int'(oldest.cursor_column),
                                int'(m_tdata[17:14]));
                    check_field("success", int'(oldest.success), int'(m_tdata[18]));
                    check_field("error_code", int'(oldest.error_code), int'(m_tdata[19]));
                    check_field("padding", 0, int'(m_tdata[23:20]));
                    check_field("last", int'(oldest.last), int'(m_tlast));
                end
            end
        end
        outstanding = pending_updates.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the character LCD text and cursor engine test: clock, reset, command
// stimulus and result back-pressure. Depends on clte_pkg, clte_checker and the block.
module testbench;
    import clte_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int items_seen;
    int results_seen;
    int updates_seen;
    int issued = 0;
    bit calm   = 1'b0;    // no idling on either side while set
    bit paused = 1'b0;
    int pick;
    int run_len;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    char_lcd_text_cursor_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    clte_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .items_seen   (items_seen),
        .results_seen (results_seen),
        .updates_seen (updates_seen)
    );

    // Result side stalls at random outside the calm stretch
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 38);
    end

    // Offer one item at a falling edge and hold it until accepted
    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                            input logic [7:0] row, input logic [7:0] col,
                            input logic setpos);
        while (!calm && $urandom_range(0, 99) < 38) begin
            s_tvalid = 1'b0;
            s_tdata  = 24'($urandom);
            s_tuser  = 4'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {col, row, ch};
        s_tuser  = {setpos, cmd};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        issued++;
        @(negedge aclk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_cmd(CMD_WRITE, ch, 8'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic place(input logic [7:0] row, input logic [7:0] col);
        send_cmd(3'($urandom), 8'($urandom), row, col, 1'b1);
    endtask

    task automatic move(input lcd_cmd_t dir);
        send_cmd(dir, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    function automatic lcd_cmd_t any_move();
        case ($urandom_range(0, 3))
            0:       return CMD_RIGHT;
            1:       return CMD_LEFT;
            2:       return CMD_UP;
            default: return CMD_DOWN;
        endcase
    endfunction

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: writes, unchanged cells, non-printables, wrap, line clear, unused code
        put_char("H");
        put_char("i");
        place(8'd0, 8'd0);
        put_char("H");
        put_char(8'd31);
        put_char(8'd127);
        put_char(8'd0);
        put_char(8'd255);
        put_char(CHAR_SPACE);
        put_char(CHAR_LAST);
        place(8'd0, 8'd1);
        send_cmd(CMD_EOL, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        send_cmd(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        place(8'd0, 8'd15);
        move(CMD_RIGHT);
        move(CMD_UP);
        move(CMD_DOWN);
        // Directed: leaving the store at both ends, bad target positions
        place(8'd0, 8'd0);
        move(CMD_LEFT);
        place(8'd1, 8'd15);
        put_char("Z");
        place(8'd1, 8'd3);
        move(CMD_DOWN);
        place(8'd0, 8'd4);
        move(CMD_UP);
        place(8'd2, 8'd0);
        place(8'd0, 8'd16);
        place(8'd255, 8'd255);
        send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // Random: mostly printable text runs and cursor moves, some noise
        while (issued < 210) begin
            if (issued >= 130 && !paused) begin
                drain();
                paused = 1'b1;
                calm   = 1'b1;
            end
            if (issued >= 180) calm = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // fill every cell, then clear it all at once
                place(8'd0, 8'd0);
                repeat (32) put_char(8'($urandom_range(33, 126)));
                send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end else if (pick < 10) begin
                place(8'($urandom_range(0, 1)), 8'($urandom_range(0, 15)));
                run_len = $urandom_range(4, 20);
                repeat (run_len) put_char(8'($urandom_range(32, 126)));
            end else if (pick < 40) begin
                put_char(8'($urandom_range(32, 126)));
            end else if (pick < 50) begin
                place(8'($urandom_range(0, 1)), 8'($urandom_range(0, 15)));
            end else if (pick < 68) begin
                move(any_move());
            end else if (pick < 74) begin
                send_cmd(CMD_EOL, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end else if (pick < 78) begin
                send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end else begin
                send_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom));
            end
        end

        drain();
        repeat (40) @(negedge aclk);
        $display("Ran %0d commands through the text store: %0d results, %0d cell updates.",
                 items_seen, results_seen, updates_seen);
        if (mismatches == 0) begin
            $display("[char_lcd_text_cursor_engine_top] OK");
        end else begin
            $display("[char_lcd_text_cursor_engine_top] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("[char_lcd_text_cursor_engine_top] ERROR");
        $finish;
    end

endmodule
